// ===== src/wlbu_pkg.sv =====
// shared constants and types for the flat-histogram bias updater
package wlbu_pkg;

	localparam int DEF_NUM_BINS   = 16;
	localparam int DEF_NUM_STAGES = 256;

	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 40;
	localparam int BOUND_W   = 35;

	localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
	localparam logic [15:0] RATIO_MIN = 16'd257;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_UPPER_ENERGY = 3'd0,
		CFG_LOWER_ENERGY = 3'd1,
		CFG_STEP_RATIO   = 3'd2,
		CFG_STEP_FLOOR   = 3'd3,
		CFG_FLATNESS_TOL = 3'd4
	} cfg_idx_t;

	localparam logic [15:0] RST_STEP_RATIO   = 16'd512;
	localparam logic [30:0] RST_STEP_FLOOR   = 31'd1073742;
	localparam logic [30:0] RST_FLATNESS_TOL = 31'd214748365;

endpackage

// ===== src/wlbu_ram.sv =====
// generic single-write, single-read ram with registered read data
module wlbu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/wlbu_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
module wlbu_div
	import wlbu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic [DIV_DEN_W:0]   rem_sub;
	logic                 qbit;

	assign rem_sh  = {rem_q, num_q[DIV_NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign qbit    = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
			num_q <= {num_q[DIV_NUM_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ===== src/wang_landau_bias_update_top.sv =====
// flat-histogram bias updater: sequencer around a shared divider and multiplier
//
// channel   direction  handshake              payload
// s_axis    in         s_tvalid / s_tready    energy, sample_count
// m_axis    out        m_tvalid / m_tready    bin_index, bin_bias, stage_index; flat in tuser
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// each sample uses the shared divider for a reciprocal, NUM_BINS visit-share divisions, one more
// when the stage advances, and NUM_BINS normalisation divisions unless the weight sum is zero;
// these divisions dominate the time a sample takes.
// reset sets the weights to 1.0 and the shares to zero through valid bits.
// s_tready is high only while idle; a finished result waits in the output
// register, and the next sample may be taken meanwhile.
module wang_landau_bias_update_top
	import wlbu_pkg::*;
#(
	parameter int NUM_BINS   = DEF_NUM_BINS,
	parameter int NUM_STAGES = DEF_NUM_STAGES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [63:0]          s_tdata,   // energy[31:0], sample_count[63:32]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [47:0]          m_tdata,   // bin_index[3:0], bin_bias[34:4], stage_index[42:35], zero
	output logic                 m_tuser,   // flat_reached
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int BIN_W   = $clog2(NUM_BINS);
	localparam int STAGE_W = $clog2(NUM_STAGES);

	// reciprocals for the constant divisions, exact for 32-bit dividends
	localparam int          D_DIV   = NUM_BINS - 1;
	localparam int          D_SH    = $clog2(D_DIV);
	localparam int          N_SH    = $clog2(NUM_BINS);
	localparam logic [63:0] D_POW   = 64'd1 << (32 + D_SH);
	localparam logic [63:0] N_POW   = 64'd1 << (32 + N_SH);
	localparam logic [32:0] D_RECIP = 33'((D_POW + 64'(D_DIV - 1)) / 64'(D_DIV));
	localparam logic [32:0] N_RECIP = 33'((N_POW + 64'(NUM_BINS - 1)) / 64'(NUM_BINS));

	typedef enum logic [23:0] {
		S_IDLE    = 24'h000001,
		S_DMUL    = 24'h000002,
		S_DSET    = 24'h000004,
		S_BIN     = 24'h000008,
		S_IDIV    = 24'h000010,
		S_IWAIT   = 24'h000020,
		S_VRD     = 24'h000040,
		S_VMUL    = 24'h000080,
		S_VDIV    = 24'h000100,
		S_VWAIT   = 24'h000200,
		S_FLAT    = 24'h000400,
		S_ADV     = 24'h000800,
		S_AWAIT   = 24'h001000,
		S_IMUL    = 24'h002000,
		S_INC     = 24'h004000,
		S_WRD     = 24'h010000,
		S_WUPD    = 24'h020000,
		S_SRD     = 24'h040000,
		S_SACC    = 24'h080000,
		S_NRD     = 24'h100000,
		S_NDIV    = 24'h200000,
		S_NWAIT   = 24'h400000,
		S_OUT     = 24'h800000
	} state_t;

	state_t state_q;

	// configuration
	logic signed [31:0] upper_q, lower_q;
	logic [15:0]        ratio_q;
	logic [30:0]        floor_q, tol_q;

	// per-sample registers
	logic signed [31:0]        energy_q;
	logic [31:0]               t_q;
	logic signed [BOUND_W-1:0] d_q, bound_q;
	logic [BIN_W-1:0]          i_q, k_q;
	logic [31:0]               inv_q, mx_q, inc_q;
	logic [DIV_DEN_W-1:0]      sum_q;
	logic [64:0]               product_q;
	logic [30:0]               bias_q;
	logic                      flat_q;

	// persistent state
	logic [STAGE_W-1:0]  stage_q;
	logic [31:0]         step_q;
	logic                harmonic_q;
	logic [NUM_BINS-1:0] visit_valid_q, weight_valid_q;

	// output register
	logic        m_tvalid_q;
	logic [3:0]  out_bin_q;
	logic [30:0] out_bias_q;
	logic [7:0]  out_stage_q;
	logic        out_flat_q;

	// shared units
	logic                 div_start, div_done;
	logic [DIV_NUM_W-1:0] div_num, div_quot;
	logic [DIV_DEN_W-1:0] div_den;
	logic [31:0]          mul_a;
	logic [32:0]          mul_b;
	logic [64:0]          mul_p;

	// memories
	logic             v_we, w_we;
	logic [BIN_W-1:0] w_waddr, w_raddr;
	logic [31:0]      v_wdata, w_wdata, v_rdata, w_rdata, v_cur, w_cur;

	// combinational helpers
	logic signed [32:0]        diff;
	logic [31:0]               diff_mag;
	logic [BOUND_W-1:0]        d_abs;
	logic signed [BOUND_W-1:0] d_new, e_ext;
	logic [15:0]               ratio_eff;
	logic [31:0]               q_clamp, v_new;
	logic [32:0]               v_add;
	logic [39:0]               scaled, dev;
	logic                      flat;
	logic [DIV_DEN_W-1:0]      sum_nx;
	logic                      s_acc;

	assign s_acc = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	assign diff     = {upper_q[31], upper_q} - {lower_q[31], lower_q};
	assign diff_mag = diff[32] ? 32'(-diff) : 32'(diff);
	assign d_abs    = {3'b000, product_q[32 + D_SH +: 32]};
	assign d_new    = diff[32] ? -$signed(d_abs) : $signed(d_abs);
	assign e_ext    = {{(BOUND_W-32){energy_q[31]}}, energy_q};

	assign ratio_eff = (ratio_q < RATIO_MIN) ? RATIO_MIN : ratio_q;

	assign v_cur = visit_valid_q[i_q] ? v_rdata : 32'd0;
	assign w_cur = (state_q == S_WUPD) ? (weight_valid_q[k_q] ? w_rdata : ONE_Q30)
	                                   : (weight_valid_q[i_q] ? w_rdata : ONE_Q30);

	assign q_clamp = (div_quot > DIV_NUM_W'(ONE_Q30)) ? ONE_Q30 : div_quot[31:0];
	assign v_add   = {1'b0, q_clamp} + {1'b0, inv_q};
	always_comb begin
		v_new = q_clamp;
		if (i_q == k_q) begin
			v_new = (v_add > {1'b0, ONE_Q30}) ? ONE_Q30 : v_add[31:0];
		end
	end

	assign scaled = 40'(mx_q) * 40'(NUM_BINS);
	assign dev    = (scaled > 40'(ONE_Q30)) ? scaled - 40'(ONE_Q30) : 40'(ONE_Q30) - scaled;
	assign flat   = dev < 40'(tol_q);

	assign sum_nx = sum_q + DIV_DEN_W'(w_cur);

	// shared multiplier operands
	always_comb begin
		mul_a = v_cur;
		mul_b = {1'b0, t_q - 32'd1};
		if (state_q == S_DMUL) begin
			mul_a = diff_mag;
			mul_b = D_RECIP;
		end else if (state_q == S_IMUL) begin
			// step*(n-1)/n is step minus ceil(step/n)
			mul_a = step_q + 32'(NUM_BINS - 1);
			mul_b = N_RECIP;
		end
	end

	assign mul_p = {33'd0, mul_a} * {32'd0, mul_b};

	// shared divider operands
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = DIV_DEN_W'(1);
		unique case (state_q)
			S_IDIV: begin
				div_start = 1'b1;
				div_num   = DIV_NUM_W'(ONE_Q30);
				div_den   = DIV_DEN_W'(t_q);
			end
			S_VDIV: begin
				div_start = 1'b1;
				div_num   = product_q[DIV_NUM_W-1:0];
				div_den   = DIV_DEN_W'(t_q);
			end
			S_ADV: begin
				div_start = 1'b1;
				if (harmonic_q) begin
					div_num = DIV_NUM_W'(ONE_Q30);
					div_den = DIV_DEN_W'(stage_q);
				end else begin
					div_num = DIV_NUM_W'({step_q, 8'd0});
					div_den = DIV_DEN_W'(ratio_eff);
				end
			end
			S_NDIV: begin
				div_start = 1'b1;
				div_num   = DIV_NUM_W'({w_cur, 30'd0});
				div_den   = sum_q;
			end
			default: begin
			end
		endcase
	end

	// memory ports
	assign v_we    = (state_q == S_VWAIT) && div_done;
	assign v_wdata = v_new;
	assign w_we    = (state_q == S_WUPD) || ((state_q == S_NWAIT) && div_done);
	assign w_waddr = (state_q == S_WUPD) ? k_q : i_q;
	assign w_raddr = (state_q == S_WRD) ? k_q : i_q;
	assign w_wdata = (state_q == S_WUPD) ? w_cur + inc_q : div_quot[31:0];

	wlbu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	wlbu_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_visit_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (i_q),
		.wdata (v_wdata),
		.raddr (i_q),
		.rdata (v_rdata)
	);

	wlbu_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= '0;
			lower_q <= '0;
			ratio_q <= RST_STEP_RATIO;
			floor_q <= RST_STEP_FLOOR;
			tol_q   <= RST_FLATNESS_TOL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_UPPER_ENERGY: upper_q <= cfg_data;
				CFG_LOWER_ENERGY: lower_q <= cfg_data;
				CFG_STEP_RATIO:   ratio_q <= cfg_data[15:0];
				CFG_STEP_FLOOR:   floor_q <= cfg_data[30:0];
				CFG_FLATNESS_TOL: tol_q   <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			stage_q        <= '0;
			step_q         <= ONE_Q30;
			harmonic_q     <= 1'b0;
			visit_valid_q  <= '0;
			weight_valid_q <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (s_acc) state_q <= S_DMUL;
				S_DMUL: state_q <= S_DSET;
				S_DSET: state_q <= S_BIN;
				S_BIN: begin
					if (e_ext > bound_q || i_q == BIN_W'(NUM_BINS - 2)) begin
						state_q <= S_IDIV;
					end
				end
				S_IDIV: state_q <= S_IWAIT;
				S_IWAIT: if (div_done) state_q <= S_VRD;
				S_VRD: state_q <= S_VMUL;
				S_VMUL: state_q <= S_VDIV;
				S_VDIV: state_q <= S_VWAIT;
				S_VWAIT: begin
					if (div_done) begin
						visit_valid_q[i_q] <= 1'b1;
						state_q <= (i_q == BIN_W'(NUM_BINS - 1)) ? S_FLAT : S_VRD;
					end
				end
				S_FLAT: begin
					state_q <= S_IMUL;
					if (flat) begin
						visit_valid_q <= '0;
						if (stage_q != STAGE_W'(NUM_STAGES - 1)) begin
							stage_q <= stage_q + 1'b1;
							state_q <= S_ADV;
						end
					end
				end
				S_ADV: state_q <= S_AWAIT;
				S_AWAIT: begin
					if (div_done) begin
						step_q <= div_quot[31:0];
						if (!harmonic_q && div_quot[31:0] < {1'b0, floor_q}) begin
							harmonic_q <= 1'b1;
						end
						state_q <= S_IMUL;
					end
				end
				S_IMUL: state_q <= S_INC;
				S_INC: state_q <= S_WRD;
				S_WRD: state_q <= S_WUPD;
				S_WUPD: begin
					weight_valid_q[k_q] <= 1'b1;
					state_q <= S_SRD;
				end
				S_SRD: state_q <= S_SACC;
				S_SACC: begin
					if (i_q == BIN_W'(NUM_BINS - 1)) begin
						state_q <= (sum_nx == '0) ? S_OUT : S_NRD;
					end else begin
						state_q <= S_SRD;
					end
				end
				S_NRD: state_q <= S_NDIV;
				S_NDIV: state_q <= S_NWAIT;
				S_NWAIT: begin
					if (div_done) begin
						weight_valid_q[i_q] <= 1'b1;
						state_q <= (i_q == BIN_W'(NUM_BINS - 1)) ? S_OUT : S_NRD;
					end
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					energy_q <= s_tdata[31:0];
					t_q      <= (s_tdata[63:32] == 32'd0) ? 32'd1 : s_tdata[63:32];
				end
			end
			S_DSET: begin
				d_q     <= d_new;
				bound_q <= {{(BOUND_W-32){upper_q[31]}}, upper_q} - d_new;
				i_q     <= '0;
			end
			S_BIN: begin
				if (e_ext > bound_q) begin
					k_q <= i_q;
				end else if (i_q == BIN_W'(NUM_BINS - 2)) begin
					k_q <= BIN_W'(NUM_BINS - 1);
				end else begin
					i_q     <= i_q + 1'b1;
					bound_q <= bound_q - d_q;
				end
			end
			S_IWAIT: begin
				if (div_done) begin
					inv_q <= div_quot[31:0];
					i_q   <= '0;
					mx_q  <= '0;
				end
			end
			S_DMUL, S_VMUL, S_IMUL: product_q <= mul_p;
			S_VWAIT: begin
				if (div_done) begin
					if (v_new > mx_q) begin
						mx_q <= v_new;
					end
					i_q <= i_q + 1'b1;
				end
			end
			S_FLAT: flat_q <= flat;
			S_INC: inc_q <= step_q - product_q[32 + N_SH +: 32];
			S_WUPD: begin
				sum_q <= '0;
				i_q   <= '0;
			end
			S_SACC: begin
				sum_q <= sum_nx;
				i_q   <= (i_q == BIN_W'(NUM_BINS - 1)) ? '0 : i_q + 1'b1;
				if (sum_nx == '0) begin
					bias_q <= '0;
				end
			end
			S_NWAIT: begin
				if (div_done) begin
					if (i_q == k_q) begin
						bias_q <= div_quot[30:0];
					end
					i_q <= i_q + 1'b1;
				end
			end
			S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_bin_q   <= 4'(k_q);
					out_bias_q  <= bias_q;
					out_stage_q <= 8'(stage_q);
					out_flat_q  <= flat_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, out_stage_q, out_bias_q, out_bin_q};
	assign m_tuser  = out_flat_q;

endmodule
